// ===== rtl/tcg_pkg.sv =====
`timescale 1ns / 1ps
package tcg_pkg;

	localparam int GLYPH_ROWS = 16;
	localparam int ROW_W      = 4;

	localparam logic ACT_DRAW = 1'b0;
	localparam logic ACT_LOAD = 1'b1;

	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] CODE_RETURN  = 8'd13;

	localparam logic [1:0] REG_BASE   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;
	localparam logic [1:0] REG_STRIDE = 2'd3;

	localparam logic [31:0] RST_BASE   = 32'd0;
	localparam logic [12:0] RST_WIDTH  = 13'd640;
	localparam logic [12:0] RST_HEIGHT = 13'd480;
	localparam logic [13:0] RST_STRIDE = 14'd640;

	localparam logic [8:0] COL_MAX = 9'd511;
	localparam logic [7:0] ROW_MAX = 8'd255;

	typedef struct packed {
		logic [31:0] base;
		logic [12:0] width;
		logic [12:0] height;
		logic [13:0] stride;
	} frame_cfg_t;

	typedef struct packed {
		logic [7:0]  code;
		logic [31:0] color;
		logic [31:0] start_addr;
		logic        known;
	} draw_job_t;

	typedef struct packed {
		logic             active;
		logic [ROW_W-1:0] row;
	} seq_stat_t;

endpackage

// ===== rtl/text_cell_glyph_renderer.sv =====
`timescale 1ns / 1ps
// A drawn character's first row beat passes the row sequencer, the glyph RAM read stage
// and the output register, each able to stall on back-pressure. One glyph row is read
// per cycle from the glyph RAM's single read port while the output is not stalled.
// Loads, newlines, returns and off-frame draws are taken when idle or at a last-row read.
// Reset clears the cursor and the handshake state and restores the frame registers to their
// defaults; the glyph RAM is not cleared and holds no valid glyph until loaded.
module text_cell_glyph_renderer
	import tcg_pkg::*;
#(
	parameter int GLYPH_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  char_code,
	input  logic [31:0] draw_color,
	input  logic [3:0]  row_index,
	input  logic [7:0]  row_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] pixel_address,
	output logic [7:0]  pixel_mask,
	output logic [31:0] pixel_color,
	output logic        last_row
);

	frame_cfg_t cfg_q;
	draw_job_t  job;
	seq_stat_t  stat;
	logic       in_fire;
	logic       job_start;
	logic       job_ready;

	assign in_ready = job_ready;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base   <= RST_BASE;
			cfg_q.width  <= RST_WIDTH;
			cfg_q.height <= RST_HEIGHT;
			cfg_q.stride <= RST_STRIDE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE:   cfg_q.base   <= cfg_data;
				REG_WIDTH:  cfg_q.width  <= cfg_data[12:0];
				REG_HEIGHT: cfg_q.height <= cfg_data[12:0];
				REG_STRIDE: cfg_q.stride <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	tcg_cursor #(
		.GLYPH_COUNT(GLYPH_COUNT)
	) u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.draw_fire (in_fire && action == ACT_DRAW),
		.char_code (char_code),
		.draw_color(draw_color),
		.cfg       (cfg_q),
		.job_start (job_start),
		.job       (job)
	);

	tcg_row_seq #(
		.GLYPH_COUNT(GLYPH_COUNT)
	) u_row_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_start    (job_start),
		.job          (job),
		.stride       (cfg_q.stride),
		.load_fire    (in_fire && action == ACT_LOAD),
		.load_code    (char_code),
		.load_row     (row_index),
		.load_bits    (row_bits),
		.job_ready    (job_ready),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_address(pixel_address),
		.pixel_mask   (pixel_mask),
		.pixel_color  (pixel_color),
		.last_row     (last_row)
	);

	// A new beat is taken only when no glyph is in flight or its final row is being read.
	a_accept_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !stat.active || stat.row == 4'd15)
		else $error("item accepted while a glyph was still being read");

	// The row counter only moves within an active character.
	a_row_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		stat.active && stat.row != 4'd0 |-> $past(stat.active))
		else $error("row counter advanced outside a character");

	// Starting a character restarts the row count at zero.
	a_start_row: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stat.active) |-> stat.row == 4'd0)
		else $error("character started at a nonzero row");

endmodule

// ===== rtl/tcg_ram.sv =====
`timescale 1ns / 1ps
module tcg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read and a write to the same entry in one cycle return the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/tcg_cursor.sv =====
`timescale 1ns / 1ps
module tcg_cursor
	import tcg_pkg::*;
#(
	parameter int GLYPH_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        draw_fire,
	input  logic [7:0]  char_code,
	input  logic [31:0] draw_color,
	input  frame_cfg_t  cfg,
	output logic        job_start,
	output draw_job_t   job
);

	logic [8:0]  col_q;
	logic [7:0]  row_q;
	logic [13:0] cell_bottom;
	logic [13:0] cell_right;
	logic [13:0] next_right;
	logic        in_frame;
	logic        is_newline;
	logic        is_return;
	logic [7:0]  row_inc;
	logic [25:0] line_off;

	assign cell_bottom = {2'b00, row_q, 4'b0000} + 14'd16;
	assign cell_right  = {2'b00, col_q, 3'b000} + 14'd8;
	assign next_right  = cell_right + 14'd8;
	assign in_frame    = (cell_bottom <= {1'b0, cfg.height}) &&
	                     (cell_right <= {1'b0, cfg.width});
	assign is_newline  = (char_code == CODE_NEWLINE);
	assign is_return   = (char_code == CODE_RETURN);
	assign row_inc     = (row_q == ROW_MAX) ? row_q : row_q + 8'd1;

	assign job_start = draw_fire && in_frame && !is_newline && !is_return;

	assign line_off = {row_q, 4'b0000} * cfg.stride;

	always_comb begin
		job.code       = char_code;
		job.color      = draw_color;
		job.known      = ({1'b0, char_code} < 9'(GLYPH_COUNT));
		job.start_addr = cfg.base + {4'b0000, line_off, 2'b00} +
		                 {18'd0, col_q, 5'b00000};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (draw_fire && in_frame) begin
			if (is_newline) begin
				row_q <= row_inc;
			end else if (is_return) begin
				col_q <= '0;
			end else if (col_q >= COL_MAX || next_right > {1'b0, cfg.width}) begin
				col_q <= '0;
				row_q <= row_inc;
			end else begin
				col_q <= col_q + 9'd1;
			end
		end
	end

endmodule

// ===== rtl/tcg_row_seq.sv =====
`timescale 1ns / 1ps
module tcg_row_seq
	import tcg_pkg::*;
#(
	parameter int GLYPH_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_start,
	input  draw_job_t   job,
	input  logic [13:0] stride,
	input  logic        load_fire,
	input  logic [7:0]  load_code,
	input  logic [3:0]  load_row,
	input  logic [7:0]  load_bits,
	output logic        job_ready,
	output seq_stat_t   stat,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] pixel_address,
	output logic [7:0]  pixel_mask,
	output logic [31:0] pixel_color,
	output logic        last_row
);

	localparam int DEPTH = GLYPH_COUNT * GLYPH_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = AW - ROW_W;
	localparam logic [ROW_W-1:0] LAST = ROW_W'(GLYPH_ROWS - 1);

	logic             active_q;
	logic [ROW_W-1:0] row_q;
	logic [7:0]       code_q;
	logic [31:0]      color_q;
	logic [31:0]      addr_q;
	logic             known_q;

	logic             valid_s1;
	logic [31:0]      addr_s1;
	logic [31:0]      color_s1;
	logic             last_s1;
	logic             known_s1;

	logic             out_valid_q;
	logic [31:0]      addr_q2_unused;
	logic [7:0]       rdata;
	logic             issue_go;
	logic             s1_move;
	logic             load_we;
	logic [AW-1:0]    waddr;
	logic [AW-1:0]    raddr;

	assign addr_q2_unused = '0;

	assign s1_move   = valid_s1 && (!out_valid_q || out_ready);
	assign issue_go  = active_q && (!valid_s1 || s1_move);
	assign job_ready = !active_q || (issue_go && row_q == LAST);

	// Unknown codes never reach the store; their rows read back as empty.
	assign load_we = load_fire && ({1'b0, load_code} < 9'(GLYPH_COUNT));
	assign waddr   = {load_code[CW-1:0], load_row};
	assign raddr   = {code_q[CW-1:0], row_q};

	tcg_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_glyph_ram (
		.clk  (clk),
		.we   (load_we),
		.waddr(waddr),
		.wdata(load_bits),
		.re   (issue_go),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			row_q    <= '0;
		end else if (job_start) begin
			active_q <= 1'b1;
			row_q    <= '0;
		end else if (issue_go) begin
			row_q <= row_q + ROW_W'(1);
			if (row_q == LAST) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_start) begin
			code_q  <= job.code;
			color_q <= job.color;
			addr_q  <= job.start_addr;
			known_q <= job.known;
		end else if (issue_go) begin
			addr_q <= addr_q + {16'd0, stride, 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue_go) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue_go) begin
			addr_s1  <= addr_q;
			color_s1 <= color_q;
			last_s1  <= (row_q == LAST);
			known_s1 <= known_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			pixel_address <= addr_s1 | addr_q2_unused;
			pixel_mask    <= known_s1 ? rdata : 8'd0;
			pixel_color   <= color_s1;
			last_row      <= last_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign stat.active = active_q;
	assign stat.row    = row_q;

endmodule
